/* sv/cdcs_pkg.sv */
// Package for the causal depthwise convolution with SiLU block.
// Holds field widths, default sizes, op and state codes and the sigmoid table.
// No dependencies.
package cdcs_pkg;

  localparam int CHANNELS_DEF = 8192;
  localparam int MAX_TAPS_DEF = 4;
  localparam int VALUE_W      = 16;
  localparam int CH_W         = 13;
  localparam int TAP_W        = 2;
  localparam int TAPS_W       = 3;
  localparam logic [TAPS_W-1:0] TAPS_RESET = 3'd4;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_HIST   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_SAT,
    ST_SILU,
    ST_EMIT
  } state_t;

  typedef logic [VALUE_W-1:0] sig_tab_t [256];

  function automatic sig_tab_t build_sig_table();
    logic [63:0] pw [129];
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    logic [127:0] prod;
    sig_tab_t tab;
    pw[0] = 64'h1_0000_0000;
    for (int j = 0; j < 128; j++) begin
      prod = 128'(pw[j]) * 128'(EXP_STEP_Q32) + 128'h8000_0000;
      pw[j + 1] = 64'(prod >> 32);
    end
    for (int k = 0; k < 256; k++) begin
      e = (k >= 128) ? pw[k - 128] : pw[128 - k];
      den = 64'h1_0000_0000 + e;
      num = (k >= 128) ? 64'h1_0000_0000_0000 : (e << 16);
      num = num + (den >> 1);
      q = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
      end
      tab[k] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

/* sv/cdcs_if.sv */
// Channel interfaces: input items, result items and the configuration write.
// Depends on cdcs_pkg.
interface cdcs_item_if import cdcs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [CH_W-1:0]           channel;
  logic [TAP_W-1:0]          tap;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, op, channel, tap, value, input ready);
  modport sink (input valid, op, channel, tap, value, output ready);
endinterface

interface cdcs_result_if import cdcs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           out_channel;
  logic signed [VALUE_W-1:0] out_value;
  logic                      is_read;
  modport source (output valid, out_channel, out_value, is_read, input ready);
  modport sink (input valid, out_channel, out_value, is_read, output ready);
endinterface

interface cdcs_cfg_if import cdcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TAPS_W-1:0] taps_in_use;
  modport source (output valid, taps_in_use, input ready);
  modport sink (input valid, taps_in_use, output ready);
endinterface

/* sv/cdcs_row_mem.sv */
// Synchronous row memory with per-lane write enables and registered read data.
// Depends on cdcs_pkg.
module cdcs_row_mem import cdcs_pkg::*; #(
  parameter int LANES = 4,
  parameter int DEPTH = 8192
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic [LANES-1:0]                     wlane,
  input  logic [LANES-1:0][VALUE_W-1:0]        wdata,
  input  logic                                 re,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic [LANES-1:0][VALUE_W-1:0]        rdata
);

  logic [LANES-1:0][VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < LANES; i++) begin
        if (wlane[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/cdcs_silu.sv */
// SiLU unit: three register stages (input, table product, rounding and range select).
// Depends on cdcs_pkg for the sigmoid table.
module cdcs_silu import cdcs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [VALUE_W-1:0] x,
  output logic                      y_valid,
  output logic signed [VALUE_W-1:0] y
);

  logic                      v0;
  logic                      v1;
  logic signed [VALUE_W-1:0] x0;
  logic signed [VALUE_W-1:0] x1;
  logic signed [32:0]        prod;
  logic [16:0]               biased;
  logic [7:0]                idx;
  logic signed [33:0]        rounded;
  logic signed [VALUE_W-1:0] y_next;

  assign biased = 17'({x0[VALUE_W-1], x0}) + 17'd8192;
  assign idx = biased[13:6];
  assign rounded = 34'(prod) + 34'sd32768;

  always_comb begin
    if (x1 >= 16'sd8192) begin
      y_next = x1;
    end else if (x1 < -16'sd8192) begin
      y_next = '0;
    end else begin
      y_next = rounded[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      y_valid <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      y_valid <= v1;
    end
    x0 <= x;
    x1 <= x0;
    prod <= x0 * $signed({1'b0, SIG_TABLE[idx]});
    y <= y_next;
  end

endmodule

/* sv/causal_depthwise_conv_silu.sv */
// Top level: per-channel causal depthwise convolution followed by SiLU.
// Depends on cdcs_pkg, cdcs_if, cdcs_row_mem and cdcs_silu.
//
// Items arrive on req (op, channel, tap, value) and results leave on rsp
// (out_channel, out_value, is_read); both use valid/ready, and a beat moves
// when both are high. cfg writes taps_in_use and is always ready.
// Weight and history writes give no result.
// A history read passes through the read and emit states to its result beat.
// A sample, with T the clamped taps_in_use, reads the channel's weight and
// history rows, runs T taps through the single multiply-accumulate unit,
// then passes rounding and saturation, the register stages of the SiLU
// unit and the output register load, after which the history row is
// already written back.
// One item is in work at a time; req is ready again once the result sits in
// the output register, so a stalled receiver holds at most one result
// while the next item is taken.
// After reset the history memory is zeroed, one row per cycle, over all
// CHANNELS rows; req.ready stays low during that pass. Weights are
// undefined until written.
module causal_depthwise_conv_silu import cdcs_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input logic          clk,
  input logic          rst,
  cdcs_item_if.sink    req,
  cdcs_result_if.source rsp,
  cdcs_cfg_if.sink     cfg
);

  localparam int HS    = MAX_TAPS - 1;
  localparam int AW    = $clog2(CHANNELS);
  localparam int KW    = $clog2(MAX_TAPS);
  localparam int TW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 2 * VALUE_W + KW + 1;

  state_t state;
  state_t state_next;

  logic [TAPS_W-1:0]         taps_in_use;
  logic [TW-1:0]             t_eff;
  logic [AW-1:0]             clr_addr;
  logic [AW-1:0]             cur_addr;
  logic [CH_W-1:0]           cur_channel;
  logic [TAP_W-1:0]          cur_tap;
  logic signed [VALUE_W-1:0] cur_value;
  logic                      rd_ok;
  logic [KW-1:0]             k;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_is_read;

  logic                      accept;
  logic                      ch_ok;
  logic [AW-1:0]             req_addr;
  logic                      mac_last;
  logic                      out_free;

  logic                          hwe;
  logic [AW-1:0]                 haddr;
  logic [HS-1:0]                 hlane;
  logic [HS-1:0][VALUE_W-1:0]    hwdata;
  logic                          hre;
  logic [HS-1:0][VALUE_W-1:0]    hist_rd;
  logic                          wwe;
  logic [MAX_TAPS-1:0]           wlane;
  logic [MAX_TAPS-1:0][VALUE_W-1:0] wwdata;
  logic                          wre;
  logic [MAX_TAPS-1:0][VALUE_W-1:0] w_rd;

  logic [MAX_TAPS-1:0][VALUE_W-1:0] hx;
  logic signed [VALUE_W-1:0]     win [MAX_TAPS];
  logic [HS-1:0][VALUE_W-1:0]    new_row;
  logic signed [VALUE_W-1:0]     rd_sel;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       shifted;
  logic signed [VALUE_W-1:0]     sat_next;
  logic                          silu_valid;
  logic signed [VALUE_W-1:0]     silu_y;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign ch_ok     = 32'(req.channel) < CHANNELS;
  assign req_addr  = AW'(req.channel);
  assign mac_last  = 32'(k) == 32'(t_eff) - 1;
  assign out_free  = !rsp.valid || rsp.ready;

  always_comb begin
    if (taps_in_use < 3'd2) begin
      t_eff = TW'(2);
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      t_eff = TW'(MAX_TAPS);
    end else begin
      t_eff = TW'(taps_in_use);
    end
  end

  assign hx = {VALUE_W'(0), hist_rd};

  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      if (i + 1 < 32'(t_eff)) begin
        win[i] = hx[i];
      end else if (i + 1 == 32'(t_eff)) begin
        win[i] = cur_value;
      end else begin
        win[i] = '0;
      end
    end
    for (int i = 0; i < HS; i++) begin
      new_row[i] = (i + 1 < 32'(t_eff)) ? win[i + 1] : hist_rd[i];
    end
    rd_sel = '0;
    for (int i = 0; i < HS; i++) begin
      if (32'(cur_tap) == i) begin
        rd_sel = hist_rd[i];
      end
    end
  end

  assign rnd     = acc + ACC_W'(8192);
  assign shifted = rnd >>> 14;

  always_comb begin
    if (shifted > ACC_W'(32767)) begin
      sat_next = 16'sh7FFF;
    end else if (shifted < -ACC_W'(32768)) begin
      sat_next = -16'sh8000;
    end else begin
      sat_next = shifted[VALUE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    hwe = 1'b0;
    haddr = cur_addr;
    hlane = '0;
    hwdata = '0;
    hre = 1'b0;
    wwe = 1'b0;
    wlane = '0;
    wwdata = '0;
    wre = 1'b0;
    case (state)
      ST_CLEAR: begin
        hwe = 1'b1;
        haddr = clr_addr;
        hlane = '1;
        if (32'(clr_addr) == CHANNELS - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < MAX_TAPS; i++) begin
            wlane[i] = (32'(req.tap) == i);
            wwdata[i] = req.value;
          end
          for (int i = 0; i < HS; i++) begin
            hlane[i] = (32'(req.tap) == i);
            hwdata[i] = req.value;
          end
          haddr = req_addr;
          case (op_t'(req.op))
            OP_WEIGHT: wwe = ch_ok && (32'(req.tap) < MAX_TAPS);
            OP_HIST: hwe = ch_ok && (32'(req.tap) < HS);
            OP_READ: begin
              hre = 1'b1;
              state_next = ST_READ;
            end
            OP_SAMPLE: begin
              if (ch_ok) begin
                hre = 1'b1;
                wre = 1'b1;
                state_next = ST_MAC;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_EMIT;
      ST_MAC: begin
        if (mac_last) begin
          hwe = 1'b1;
          hlane = '1;
          hwdata = new_row;
          state_next = ST_SAT;
        end
      end
      ST_SAT: state_next = ST_SILU;
      ST_SILU: begin
        if (silu_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      taps_in_use <= TAPS_RESET;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg.valid && cfg.ready) begin
        taps_in_use <= cfg.taps_in_use;
      end
      if (state == ST_EMIT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (accept) begin
      cur_addr <= req_addr;
      cur_channel <= req.channel;
      cur_tap <= req.tap;
      cur_value <= req.value;
      rd_ok <= ch_ok && (32'(req.tap) < HS);
      k <= '0;
      acc <= '0;
    end
    if (state == ST_MAC) begin
      acc <= acc + ACC_W'(win[k] * $signed(w_rd[k]));
      k <= k + KW'(1);
    end
    if (state == ST_READ) begin
      res_value <= rd_ok ? rd_sel : '0;
      res_is_read <= 1'b1;
    end
    if (state == ST_SILU && silu_valid) begin
      res_value <= silu_y;
      res_is_read <= 1'b0;
    end
    if (state == ST_EMIT && out_free) begin
      rsp.out_channel <= cur_channel;
      rsp.out_value <= res_value;
      rsp.is_read <= res_is_read;
    end
  end

  cdcs_row_mem #(.LANES(HS), .DEPTH(CHANNELS)) u_hist (
    .clk   (clk),
    .we    (hwe),
    .waddr (haddr),
    .wlane (hlane),
    .wdata (hwdata),
    .re    (hre),
    .raddr (req_addr),
    .rdata (hist_rd)
  );

  cdcs_row_mem #(.LANES(MAX_TAPS), .DEPTH(CHANNELS)) u_weight (
    .clk   (clk),
    .we    (wwe),
    .waddr (req_addr),
    .wlane (wlane),
    .wdata (wwdata),
    .re    (wre),
    .raddr (req_addr),
    .rdata (w_rd)
  );

  cdcs_silu u_silu (
    .clk      (clk),
    .rst      (rst),
    .in_valid (state == ST_SAT),
    .x        (sat_next),
    .y_valid  (silu_valid),
    .y        (silu_y)
  );

endmodule

/* sv/cdcs_checker.sv */
// Port-level assertions for causal_depthwise_conv_silu, with the bind that attaches them.
// Depends on cdcs_pkg and the top level.
module cdcs_checker import cdcs_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic [1:0]                req_op,
  input logic [CH_W-1:0]           req_channel,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic signed [VALUE_W-1:0] rsp_out_value,
  input logic                      rsp_is_read
);

  a_clear_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("Input taken during the history clearing pass.");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op == OP_SAMPLE && 32'(req_channel) < CHANNELS)
      |=> !req_ready)
    else $error("Input taken while a sample is in work.");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_op == OP_READ) |=> !req_ready)
    else $error("Input taken while a history read is in work.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_value) && $stable(rsp_is_read)))
    else $error("Stalled result beat changed.");

endmodule

bind causal_depthwise_conv_silu cdcs_checker #(.CHANNELS(CHANNELS)) u_cdcs_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_op        (req.op),
  .req_channel   (req.channel),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_out_value (rsp.out_value),
  .rsp_is_read   (rsp.is_read)
);
